### rtl/core/vpi_pkg.sv
// Shared types, codes and saturating arithmetic for the Verlet position integrator.
// No dependencies; imported by the lane, the top level, the checker and the bench.
package vpi_pkg;

   localparam int BODY_W = 10;
   localparam int DT_W   = 16;
   localparam int ACC_W  = 32;
   localparam int POS_W  = 48;

   // action codes
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD   = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_ADD  = 5'b01000,
      ST_WB   = 5'b10000
   } state_type;

   // Sequencer strobes shared by all three lanes
   typedef struct packed {
      logic       rd;
      logic       mul;
      logic       add;
      logic       wb;
      logic [1:0] action;
   } vpi_ctrl_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? S64_MIN : S64_MAX;
      end
      return s[63:0];
   endfunction

endpackage

### rtl/core/vpi_lane.sv
// One axis of the integrator: current/previous position memories and the
// Euler/Verlet datapath. Depends on vpi_pkg.
module vpi_lane
   import vpi_pkg::*;
#(
   parameter int MAX_BODIES     = 1024,
   parameter int POSITION_WIDTH = 48,
   parameter int IDX_W          = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1
) (
   input  logic                    clock,
   input  vpi_ctrl_type            ctrl,
   input  logic [IDX_W-1:0]        index,
   input  logic [DT_W-1:0]         dt_i,
   input  logic signed [ACC_W-1:0] acc_i,
   input  logic signed [POS_W-1:0] vec_i,
   output logic signed [POS_W-1:0] pos_o
);

   localparam logic signed [63:0] POS_HI = (64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] POS_LO = -POS_HI - 64'sd1;

   function automatic logic signed [POSITION_WIDTH-1:0] sat_pos(input logic signed [63:0] v);
      if (v > POS_HI) begin
         return POSITION_WIDTH'(POS_HI);
      end
      if (v < POS_LO) begin
         return POSITION_WIDTH'(POS_LO);
      end
      return POSITION_WIDTH'(v);
   endfunction

   logic signed [POSITION_WIDTH-1:0] cur_mem  [MAX_BODIES];
   logic signed [POSITION_WIDTH-1:0] prev_mem [MAX_BODIES];

   logic signed [POSITION_WIDTH-1:0] cur_rd_ff, prev_rd_ff;
   logic [31:0]                      dt2_ff, dt2_in;
   logic signed [63:0]               vdt_ff, vdt_in;
   logic signed [63:0]               accp_ff, accp_in;
   logic signed [63:0]               sum_ff, sum_in;

   logic signed [63:0]               cur64, prev64, vec64, neg_prev;
   logic signed [POSITION_WIDTH-1:0] final_pos;

   assign cur64    = 64'(cur_rd_ff);
   assign prev64   = 64'(prev_rd_ff);
   assign vec64    = 64'(vec_i);
   assign neg_prev = (prev64 == S64_MIN) ? S64_MAX : -prev64;

   // operands widened first so the products are exact
   assign dt2_in  = 32'(dt_i) * 32'(dt_i);
   assign vdt_in  = 64'(vec_i) * 64'($signed({1'b0, dt_i}));
   assign accp_in = 64'(acc_i) * 64'($signed({1'b0, dt2_ff}));

   // Saturating adds spread over MUL, ADD and WB: three for STEP, two for START
   always_comb begin
      sum_in = sum_ff;
      if (ctrl.mul) begin
         if (ctrl.action == ACT_START) begin
            sum_in = sat_add64(cur64, vdt_ff >>> 8);
         end else begin
            sum_in = sat_add64(cur64, cur64);
         end
      end else if (ctrl.add) begin
         if (ctrl.action == ACT_START) begin
            sum_in = sat_add64(sum_ff, accp_ff >>> 25);
         end else begin
            sum_in = sat_add64(sum_ff, neg_prev);
         end
      end
   end

   always_comb begin
      case (ctrl.action)
         ACT_LOAD:  final_pos = sat_pos(vec64);
         ACT_START: final_pos = sat_pos(sum_ff);
         ACT_STEP:  final_pos = sat_pos(sat_add64(sum_ff, accp_ff >>> 24));
         default:   final_pos = cur_rd_ff;
      endcase
   end

   assign pos_o = POS_W'(final_pos);

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         cur_rd_ff  <= cur_mem[index];
         prev_rd_ff <= prev_mem[index];
         dt2_ff     <= dt2_in;
         vdt_ff     <= vdt_in;
      end
      if (ctrl.mul) begin
         accp_ff <= accp_in;
      end
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.wb) begin
         case (ctrl.action) inside
            ACT_LOAD: begin
               cur_mem[index] <= final_pos;
            end
            ACT_START, ACT_STEP: begin
               prev_mem[index] <= cur_rd_ff;
               cur_mem[index]  <= final_pos;
            end
            default: ;
         endcase
      end
   end

endmodule

### rtl/core/verlet_position_integrator.sv
// Verlet position integrator top level: sequencer, three axis lanes and the
// result register that merges them. Depends on vpi_pkg and vpi_lane.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   action, body, time_step, accel, vec
//   rsp_      out        rsp_valid/rsp_stall   out_body, pos_x/y/z
//
// An item passes through table read, multiply, add and write-back states; the next
// item is taken in the write-back cycle once the result register is free. The
// registered table read feeds the multiply and add stages. Synchronous
// active-high reset clears the sequencer and rsp_valid; the tables are not
// cleared. A stalled result holds write-back until the result register frees up.
module verlet_position_integrator
   import vpi_pkg::*;
#(
   parameter int MAX_BODIES     = 1024,
   parameter int POSITION_WIDTH = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_action,
   input  logic [BODY_W-1:0]       req_body,
   input  logic [DT_W-1:0]         req_time_step,
   input  logic signed [ACC_W-1:0] req_accel_x,
   input  logic signed [ACC_W-1:0] req_accel_y,
   input  logic signed [ACC_W-1:0] req_accel_z,
   input  logic signed [POS_W-1:0] req_vec_x,
   input  logic signed [POS_W-1:0] req_vec_y,
   input  logic signed [POS_W-1:0] req_vec_z,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [BODY_W-1:0]       rsp_out_body,
   output logic signed [POS_W-1:0] rsp_pos_x,
   output logic signed [POS_W-1:0] rsp_pos_y,
   output logic signed [POS_W-1:0] rsp_pos_z
);

   localparam int IDX_W  = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam int WRAP_W = 2 * BODY_W;
   localparam logic [WRAP_W-1:0] WRAP_MAX = WRAP_W'(MAX_BODIES);

   // body modulo MAX_BODIES by conditional subtraction of shifted multiples
   function automatic logic [BODY_W-1:0] body_wrap(input logic [BODY_W-1:0] b);
      logic [WRAP_W-1:0] v;
      v = WRAP_W'(b);
      if (MAX_BODIES < (1 << BODY_W)) begin
         for (int k = BODY_W - 1; k >= 0; k--) begin
            if (v >= (WRAP_MAX << k)) begin
               v = v - (WRAP_MAX << k);
            end
         end
      end
      return BODY_W'(v);
   endfunction

   state_type state_ff, state_in;
   logic [1:0]              action_ff;
   logic [BODY_W-1:0]       body_ff;
   logic [DT_W-1:0]         dt_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [POS_W-1:0] vec_ff [3];
   logic signed [POS_W-1:0] lane_pos [3];

   logic rsp_valid_ff, rsp_valid_in;
   logic [BODY_W-1:0]       rsp_body_ff;
   logic signed [POS_W-1:0] rsp_pos_ff [3];

   logic         accept, out_free, wb_fire;
   vpi_ctrl_type ctrl;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wb_fire   = (state_ff == ST_WB) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || wb_fire);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RD;
         ST_RD:   state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = ST_WB;
         ST_WB: begin
            if (out_free) begin
               state_in = accept ? ST_RD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ctrl.rd     = (state_ff == ST_RD);
   assign ctrl.mul    = (state_ff == ST_MUL);
   assign ctrl.add    = (state_ff == ST_ADD);
   assign ctrl.wb     = wb_fire;
   assign ctrl.action = action_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         body_ff   <= body_wrap(req_body);
         dt_ff     <= req_time_step;
         acc_ff[0] <= req_accel_x;
         acc_ff[1] <= req_accel_y;
         acc_ff[2] <= req_accel_z;
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      vpi_lane #(
         .MAX_BODIES     (MAX_BODIES),
         .POSITION_WIDTH (POSITION_WIDTH),
         .IDX_W          (IDX_W)
      ) u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .index (IDX_W'(body_ff)),
         .dt_i  (dt_ff),
         .acc_i (acc_ff[g]),
         .vec_i (vec_ff[g]),
         .pos_o (lane_pos[g])
      );
   end

   // result register merges the three lanes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (wb_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_fire) begin
         rsp_body_ff   <= body_ff;
         rsp_pos_ff[0] <= lane_pos[0];
         rsp_pos_ff[1] <= lane_pos[1];
         rsp_pos_ff[2] <= lane_pos[2];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_body = rsp_body_ff;
   assign rsp_pos_x    = rsp_pos_ff[0];
   assign rsp_pos_y    = rsp_pos_ff[1];
   assign rsp_pos_z    = rsp_pos_ff[2];

endmodule

### rtl/core/vpi_checker.sv
// Port-level checks for verlet_position_integrator, attached by bind.
// Depends on vpi_pkg for field widths.
module vpi_checker
   import vpi_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [BODY_W-1:0]       rsp_out_body,
   input logic signed [POS_W-1:0] rsp_pos_x,
   input logic signed [POS_W-1:0] rsp_pos_y,
   input logic signed [POS_W-1:0] rsp_pos_z
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_body) &&
         $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_pos_z))
      else $error("result item changed while stalled");

   // one item at a time: busy through read, multiply and add
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall ##1 req_stall)
      else $error("item taken while previous item in flight");

   // a fresh result follows its item through read, multiply, add and write-back
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 5))
      else $error("result without matching item");

endmodule

bind verlet_position_integrator vpi_checker u_vpi_checker (.*);

### bench/verlet_position_integrator_tb.sv
// Self-checking bench for verlet_position_integrator: directed corner items, then
// random load/start/step/unused trajectories under sender gaps and receiver stalls.
// Depends on vpi_pkg and the integrator RTL only.
`timescale 1ns / 1ps

module verlet_position_integrator_tb
   import vpi_pkg::*;
();

   localparam int NUM_BODIES   = 1024;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic signed [79:0] POS_HI80 = {33'd0, {(POS_W-1){1'b1}}};
   localparam logic signed [79:0] POS_LO80 = ~POS_HI80;
   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]              action;
      logic [BODY_W-1:0]       body;
      logic [DT_W-1:0]         dt;
      logic [2:0][ACC_W-1:0]   accel;
      logic [2:0][POS_W-1:0]   vec;
   } motion_item_type;

   typedef struct packed {
      logic [BODY_W-1:0]       body;
      logic [2:0][POS_W-1:0]   pos;
   } position_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_action;
   logic [BODY_W-1:0]       req_body;
   logic [DT_W-1:0]         req_time_step;
   logic signed [ACC_W-1:0] req_accel_x, req_accel_y, req_accel_z;
   logic signed [POS_W-1:0] req_vec_x, req_vec_y, req_vec_z;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [BODY_W-1:0]       rsp_out_body;
   logic signed [POS_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;

   // body table mirror, index 0 = x
   logic [2:0][POS_W-1:0] cur_tab  [0:NUM_BODIES-1];
   logic [2:0][POS_W-1:0] prev_tab [0:NUM_BODIES-1];
   bit                    cur_known  [0:NUM_BODIES-1];
   bit                    prev_known [0:NUM_BODIES-1];

   position_type pending_positions[$];
   int        mismatch_count;
   int        cycle_count;
   int        burst_left;
   int        stall_left;
   int        stall_mode;

   verlet_position_integrator u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_body      (req_body),
      .req_time_step (req_time_step),
      .req_accel_x   (req_accel_x),
      .req_accel_y   (req_accel_y),
      .req_accel_z   (req_accel_z),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_body  (rsp_out_body),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- position arithmetic ----------------

   function automatic logic [POS_W-1:0] clamp_pos(input logic signed [79:0] v);
      if (v > POS_HI80) return POS_MAX;
      if (v < POS_LO80) return POS_MIN;
      return v[POS_W-1:0];
   endfunction

   // products are exact at 80 bits; >>> on a signed value floors
   function automatic logic [POS_W-1:0] euler_pos(input logic [POS_W-1:0] start,
                                                  input logic [POS_W-1:0] vel,
                                                  input logic [ACC_W-1:0] acc,
                                                  input logic [DT_W-1:0] dt);
      logic signed [79:0] s80, v80, a80, dt80;
      s80  = $signed(start);
      v80  = $signed(vel);
      a80  = $signed(acc);
      dt80 = {64'd0, dt};
      return clamp_pos(s80 + ((v80 * dt80) >>> 8) + ((a80 * dt80 * dt80) >>> 25));
   endfunction

   function automatic logic [POS_W-1:0] verlet_pos(input logic [POS_W-1:0] cur,
                                                   input logic [POS_W-1:0] prev,
                                                   input logic [ACC_W-1:0] acc,
                                                   input logic [DT_W-1:0] dt);
      logic signed [79:0] c80, p80, a80, dt80;
      c80  = $signed(cur);
      p80  = $signed(prev);
      a80  = $signed(acc);
      dt80 = {64'd0, dt};
      return clamp_pos(c80 + c80 - p80 + ((a80 * dt80 * dt80) >>> 24));
   endfunction

   // advances the mirrored table by one item and returns the position it reports
   function automatic position_type integrate_body(input motion_item_type it);
      position_type res;
      logic [2:0][POS_W-1:0] next_pos;
      next_pos = cur_tab[it.body];
      for (int a = 0; a < 3; a++) begin
         case (it.action)
            ACT_LOAD:  next_pos[a] = it.vec[a];
            ACT_START: next_pos[a] = euler_pos(cur_tab[it.body][a], it.vec[a],
                                               it.accel[a], it.dt);
            ACT_STEP:  next_pos[a] = verlet_pos(cur_tab[it.body][a], prev_tab[it.body][a],
                                                it.accel[a], it.dt);
            default: ;
         endcase
      end
      if (it.action == ACT_START || it.action == ACT_STEP) begin
         prev_tab[it.body]   = cur_tab[it.body];
         prev_known[it.body] = 1'b1;
      end
      if (it.action == ACT_LOAD) cur_known[it.body] = 1'b1;
      cur_tab[it.body] = next_pos;
      res.body = it.body;
      res.pos  = next_pos;
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic motion_item_type make_item(input logic [1:0] action,
                                                 input logic [BODY_W-1:0] body,
                                                 input logic [DT_W-1:0] dt,
                                                 input logic [ACC_W-1:0] ax, ay, az,
                                                 input logic [POS_W-1:0] vx, vy, vz);
      motion_item_type it;
      it.action = action;
      it.body   = body;
      it.dt     = dt;
      it.accel  = {az, ay, ax};
      it.vec    = {vz, vy, vx};
      return it;
   endfunction

   function automatic logic [POS_W-1:0] pick_vec();
      logic [63:0]             r;
      logic signed [POS_W-1:0] m;
      r = {$urandom, $urandom};
      m = POS_W'($signed(r[31:0]));
      case ($urandom_range(0, 9)) inside
         0, 1:    return r[POS_W-1:0];
         2:       return POS_MAX;
         3:       return POS_MIN;
         4:       return r[0] ? '0 : '1;
         default: return m >>> $urandom_range(0, 10);
      endcase
   endfunction

   function automatic logic [ACC_W-1:0] pick_accel();
      logic signed [ACC_W-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 9)) inside
         0, 1:    return r;
         2:       return r[0] ? ACC_MAX : ACC_MIN;
         3:       return '0;
         default: return r >>> $urandom_range(4, 16);
      endcase
   endfunction

   function automatic logic [DT_W-1:0] r_dt_corner();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return 16'd1;
         default: return '1;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] pick_dt();
      case ($urandom_range(0, 9)) inside
         0, 1:    return DT_W'($urandom);
         2:       return r_dt_corner();
         default: return DT_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // only actions whose table reads have been written before
   function automatic logic [1:0] pick_action(input logic [BODY_W-1:0] body);
      int roll;
      roll = $urandom_range(0, 99);
      if (!cur_known[body]) return ACT_LOAD;
      if (!prev_known[body]) begin
         if (roll < 20) return ACT_LOAD;
         if (roll < 90) return ACT_START;
         return ACT_UNUSED;
      end
      if (roll < 10) return ACT_LOAD;
      if (roll < 25) return ACT_START;
      if (roll < 90) return ACT_STEP;
      return ACT_UNUSED;
   endfunction

   // ---------------- driving ----------------

   task automatic send_item(input motion_item_type it);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_action    <= it.action;
      req_body      <= it.body;
      req_time_step <= it.dt;
      req_accel_x   <= it.accel[0];
      req_accel_y   <= it.accel[1];
      req_accel_z   <= it.accel[2];
      req_vec_x     <= it.vec[0];
      req_vec_y     <= it.vec[1];
      req_vec_z     <= it.vec[2];
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_positions.push_back(integrate_body(it));
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern: stretches of none, light, heavy and alternating stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
         end
         stall_left--;
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            2:       rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= cycle_count[0];
         endcase
      end
   end

   // ---------------- checking ----------------

   always @(posedge clock) begin
      position_type          want;
      logic [2:0][POS_W-1:0] got;
      string                 axis_name;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_positions.size() == 0) begin
            $error("unexpected result item for body %0d", rsp_out_body);
            mismatch_count++;
         end else begin
            want = pending_positions.pop_front();
            got  = {rsp_pos_z, rsp_pos_y, rsp_pos_x};
            if (rsp_out_body !== want.body) begin
               $error("out_body mismatch: expected %0d actual %0d", want.body, rsp_out_body);
               mismatch_count++;
            end
            for (int a = 0; a < 3; a++) begin
               axis_name = (a == 0) ? "pos_x" : (a == 1) ? "pos_y" : "pos_z";
               if (got[a] !== want.pos[a]) begin
                  $error("%s mismatch: expected %h actual %h", axis_name, want.pos[a], got[a]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------- tests ----------------

   task automatic test_load_extremes();
      send_item(make_item(ACT_LOAD, 10'd0, '0, '0, '0, '0, POS_MAX, POS_MIN, '1));
      send_item(make_item(ACT_LOAD, 10'd1023, '1, ACC_MAX, ACC_MIN, '1,
                          POS_MIN, POS_MAX, '0));
      send_item(make_item(ACT_LOAD, 10'd1, 16'd1, '0, '0, '0,
                          48'sd16777216, -48'sd50331648, 48'sd123456));
      send_item(make_item(ACT_LOAD, 10'd2, '0, '0, '0, '0, '0, '0, '0));
   endtask

   // positive and negative saturation, zero time step, smallest time step
   task automatic test_euler_start();
      send_item(make_item(ACT_START, 10'd0, '1, ACC_MAX, ACC_MIN, ACC_MAX,
                          POS_MAX, POS_MIN, POS_MAX));
      send_item(make_item(ACT_START, 10'd1023, '0, ACC_MAX, ACC_MAX, ACC_MIN,
                          POS_MAX, POS_MAX, POS_MIN));
      send_item(make_item(ACT_START, 10'd1, 16'd1, -32'sd65536, 32'sd3, -32'sd1,
                          48'sd65536, -48'sd1, 48'sd7));
      send_item(make_item(ACT_START, 10'd2, '1, ACC_MIN, ACC_MAX, '0,
                          -48'sd65536, 48'sd196608, '0));
   endtask

   // includes back-to-back items on one body and a load right before a step
   task automatic test_verlet_step();
      send_item(make_item(ACT_STEP, 10'd0, '1, ACC_MAX, ACC_MIN, ACC_MIN, '0, '0, '0));
      send_item(make_item(ACT_STEP, 10'd1, 16'd32768, 32'sd65536, -32'sd65536, '1,
                          '0, '0, '0));
      send_item(make_item(ACT_STEP, 10'd1, 16'd32768, 32'sd65536, -32'sd65536, '1,
                          '0, '0, '0));
      send_item(make_item(ACT_STEP, 10'd1023, '0, ACC_MAX, ACC_MAX, ACC_MAX, '1, '1, '1));
      send_item(make_item(ACT_STEP, 10'd2, '1, ACC_MAX, ACC_MIN, '1, '0, '0, '0));
      send_item(make_item(ACT_LOAD, 10'd1, '0, '0, '0, '0, POS_MIN, POS_MAX, '0));
      send_item(make_item(ACT_STEP, 10'd1, '1, ACC_MIN, ACC_MAX, '0, '0, '0, '0));
   endtask

   // unused action code leaves the body alone and reports its position
   task automatic test_unused_action();
      send_item(make_item(ACT_UNUSED, 10'd1, '1, ACC_MAX, ACC_MIN, '1,
                          POS_MAX, POS_MIN, '1));
      send_item(make_item(ACT_UNUSED, 10'd0, '0, '0, '0, '0, '0, '0, '0));
      send_item(make_item(ACT_LOAD, 10'd5, '0, '0, '0, '0, 48'sd1, -48'sd2, 48'sd3));
      send_item(make_item(ACT_UNUSED, 10'd5, '1, ACC_MIN, ACC_MIN, ACC_MIN,
                          POS_MIN, POS_MIN, POS_MIN));
   endtask

   task automatic test_random_trajectories(input int count);
      motion_item_type   it;
      logic [BODY_W-1:0] body, last_body;
      int                done, roll;
      done      = 0;
      last_body = '0;
      while (done < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 25)      body = last_body;
         else if (roll < 75) body = BODY_W'($urandom_range(0, 7));
         else                body = BODY_W'($urandom_range(0, NUM_BODIES - 1));
         it = make_item(pick_action(body), body, pick_dt(),
                        pick_accel(), pick_accel(), pick_accel(),
                        pick_vec(), pick_vec(), pick_vec());
         done++;
         send_item(it);
         last_body = body;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_LOAD;
      req_body       = '0;
      req_time_step  = '0;
      req_accel_x    = '0;
      req_accel_y    = '0;
      req_accel_z    = '0;
      req_vec_x      = '0;
      req_vec_y      = '0;
      req_vec_z      = '0;
      rsp_stall      = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      burst_left     = 0;
      stall_left     = 0;
      stall_mode     = 0;
      for (int i = 0; i < NUM_BODIES; i++) begin
         cur_tab[i]    = '0;
         prev_tab[i]   = '0;
         cur_known[i]  = 1'b0;
         prev_known[i] = 1'b0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_load_extremes();
      test_euler_start();
      test_verlet_step();
      test_unused_action();
      test_random_trajectories(800);
      wait_results_drained();
      test_random_trajectories(800);

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/vpi_pkg.sv
rtl/core/vpi_lane.sv
rtl/core/verlet_position_integrator.sv
rtl/core/vpi_checker.sv
bench/verlet_position_integrator_tb.sv
